FILE: hdl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants for the positional list store
// Word layouts for the request and response channels, cell command format,
// operation and status codes, and the sizes derived from the list capacity.
// ----------------------------------------------------------------------------
package pls_pkg;

   // list capacity and derived widths
   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W    = ((COUNT_W > 7) ? COUNT_W : 7) + 1;
   localparam int DATA_W   = 32;

   // request kinds
   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_INSERT     = 3'd2;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
   localparam logic [2:0] KIND_POP_BACK   = 3'd4;
   localparam logic [2:0] KIND_REMOVE     = 3'd5;
   localparam logic [2:0] KIND_READ       = 3'd6;

   // response status
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;
   localparam logic [1:0] STAT_BAD   = 2'd3;

   // cell operations
   localparam logic [1:0] OP_NONE   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   typedef struct packed {
      logic [2:0]               kind;
      logic [6:0]               position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [1:0]               status;
      logic [6:0]               entry_count;
      logic                     list_empty;
   } rsp_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                     en;
      logic [1:0]               op;
      logic [IDX_W-1:0]         idx;
      logic signed [DATA_W-1:0] value;
   } cmd_type;

endpackage

FILE: hdl/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell: one storage slot of the list chain
// Holds one entry. On insert a cell past the point takes its left neighbor and
// the cell at the point takes the new value; on delete cells at or past it take
// their right neighbor. On read the addressed cell presents its entry on its
// read output, all others zero; the read output holds until the next command.
// ----------------------------------------------------------------------------
module pls_cell (
   input  logic                             clock,
   input  pls_pkg::cmd_type                 cmd,
   input  logic [pls_pkg::IDX_W-1:0]        cell_index,
   input  logic signed [pls_pkg::DATA_W-1:0] left_data,
   input  logic signed [pls_pkg::DATA_W-1:0] right_data,
   output logic signed [pls_pkg::DATA_W-1:0] data_out,
   output logic signed [pls_pkg::DATA_W-1:0] rd_out
);

   logic signed [pls_pkg::DATA_W-1:0] data_ff, data_in;
   logic signed [pls_pkg::DATA_W-1:0] rd_ff, rd_in;
   logic                              at_idx, past_idx;

   assign at_idx   = (cell_index == cmd.idx);
   assign past_idx = (cell_index > cmd.idx);

   // entry update: shift toward back on insert, toward front on delete
   always_comb begin
      data_in = data_ff;
      rd_in   = rd_ff;
      if (cmd.en) begin
         rd_in = '0;
         case (cmd.op)
            pls_pkg::OP_INSERT: begin
               if (past_idx) begin
                  data_in = left_data;
               end else if (at_idx) begin
                  data_in = cmd.value;
               end
            end
            pls_pkg::OP_DELETE: begin
               if (past_idx || at_idx) begin
                  data_in = right_data;
               end
            end
            pls_pkg::OP_READ: begin
               if (at_idx) begin
                  rd_in = data_ff;
               end
            end
            default: begin
               data_in = data_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rd_ff   <= rd_in;
   end

   assign data_out = data_ff;
   assign rd_out   = rd_ff;

endmodule

FILE: hdl/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store: bounded ordered list of signed 32-bit entries
// A chain of storage cells with a small sequencer in front of it.
// ----------------------------------------------------------------------------
// Each request word has three steps: in idle it is checked against the count
// and its position picked; in shift every cell behind the position moves by
// one slot at once; in drain the cells' read outputs are ORed together into
// the response register. A new request is taken only in idle, after the last
// word has gone to the response register; that register frees the chain while
// a finished word waits. Status is checked first and the list is left unchanged
// for any status other than ok. Entries above the count are never seen.
// ----------------------------------------------------------------------------
module positional_list_store (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pls_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pls_pkg::rsp_type rsp_word
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SHIFT = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [pls_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [1:0]                     status_ff, status_in;
   pls_pkg::cmd_type               cmd_ff, cmd_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   pls_pkg::rsp_type               rsp_word_ff, rsp_word_in;

   logic                           req_accept;
   logic [pls_pkg::CMP_W-1:0]      pos_ext, cnt_ext;
   logic                           cnt_full, cnt_zero;
   logic [pls_pkg::IDX_W-1:0]      pos_idx;

   logic signed [pls_pkg::DATA_W-1:0] cell_data [pls_pkg::CAPACITY];
   logic signed [pls_pkg::DATA_W-1:0] cell_rd   [pls_pkg::CAPACITY];
   logic signed [pls_pkg::DATA_W-1:0] rd_or;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign pos_ext  = pls_pkg::CMP_W'(req_word.position);
   assign cnt_ext  = pls_pkg::CMP_W'(count_ff);
   assign cnt_full = (cnt_ext == pls_pkg::CMP_W'(pls_pkg::CAPACITY));
   assign cnt_zero = (count_ff == '0);
   assign pos_idx  = pls_pkg::IDX_W'(req_word.position - 7'd1);

   // request decode: status, cell command and new count
   always_comb begin
      status_in       = pls_pkg::STAT_OK;
      cmd_in.en       = 1'b1;
      cmd_in.op       = pls_pkg::OP_NONE;
      cmd_in.idx      = '0;
      cmd_in.value    = req_word.value;
      count_in        = count_ff;
      unique case (req_word.kind) inside
         pls_pkg::KIND_PUSH_FRONT, pls_pkg::KIND_PUSH_BACK, pls_pkg::KIND_INSERT: begin
            if (req_word.kind == pls_pkg::KIND_INSERT &&
                (pos_ext == '0 || pos_ext > cnt_ext + pls_pkg::CMP_W'(1))) begin
               status_in = pls_pkg::STAT_BAD;
            end else if (cnt_full) begin
               status_in = pls_pkg::STAT_FULL;
            end else begin
               cmd_in.op = pls_pkg::OP_INSERT;
               count_in  = count_ff + pls_pkg::COUNT_W'(1);
               if (req_word.kind == pls_pkg::KIND_PUSH_BACK) begin
                  cmd_in.idx = pls_pkg::IDX_W'(count_ff);
               end else if (req_word.kind == pls_pkg::KIND_INSERT) begin
                  cmd_in.idx = pos_idx;
               end
            end
         end
         pls_pkg::KIND_POP_FRONT, pls_pkg::KIND_POP_BACK,
         pls_pkg::KIND_REMOVE, pls_pkg::KIND_READ: begin
            if (cnt_zero) begin
               status_in = pls_pkg::STAT_EMPTY;
            end else if ((req_word.kind == pls_pkg::KIND_REMOVE ||
                          req_word.kind == pls_pkg::KIND_READ) &&
                         (pos_ext == '0 || pos_ext > cnt_ext)) begin
               status_in = pls_pkg::STAT_BAD;
            end else begin
               if (req_word.kind == pls_pkg::KIND_POP_BACK) begin
                  cmd_in.idx = pls_pkg::IDX_W'(count_ff - pls_pkg::COUNT_W'(1));
               end else if (req_word.kind != pls_pkg::KIND_POP_FRONT) begin
                  cmd_in.idx = pos_idx;
               end
               if (req_word.kind == pls_pkg::KIND_READ) begin
                  cmd_in.op = pls_pkg::OP_READ;
               end else begin
                  cmd_in.op = pls_pkg::OP_DELETE;
                  count_in  = count_ff - pls_pkg::COUNT_W'(1);
               end
            end
         end
         default: begin
            status_in = pls_pkg::STAT_OK;
         end
      endcase
   end

   // sequencer and response register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.read_value  = rd_or;
               rsp_word_in.status      = status_ff;
               rsp_word_in.entry_count = 7'(count_ff);
               rsp_word_in.list_empty  = cnt_zero;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cmd_ff.en    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff.en    <= req_accept;
         if (req_accept) begin
            count_ff     <= count_in;
            cmd_ff.op    <= cmd_in.op;
            cmd_ff.idx   <= cmd_in.idx;
            cmd_ff.value <= cmd_in.value;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (req_accept) begin
         status_ff <= status_in;
      end
   end

   // cell chain
   for (genvar i = 0; i < pls_pkg::CAPACITY; i++) begin : g_cell
      logic signed [pls_pkg::DATA_W-1:0] left_w, right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_data[i-1];
      end
      if (i == pls_pkg::CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_data[i+1];
      end
      pls_cell u_cell (
         .clock      (clock),
         .cmd        (cmd_ff),
         .cell_index (pls_pkg::IDX_W'(i)),
         .left_data  (left_w),
         .right_data (right_w),
         .data_out   (cell_data[i]),
         .rd_out     (cell_rd[i])
      );
   end

   // read collect: only the addressed cell drives nonzero
   always_comb begin
      rd_or = '0;
      for (int k = 0; k < pls_pkg::CAPACITY; k++) begin
         rd_or = rd_or | cell_rd[k];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: hdl/pls_checker.sv
// ----------------------------------------------------------------------------
// pls_checker: port-level checks for the positional list store
// Watches the request and response channels and flags inconsistent words.
// ----------------------------------------------------------------------------
module pls_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input pls_pkg::req_type req_word,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pls_pkg::rsp_type rsp_word
);

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // empty flag agrees with count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.list_empty == (rsp_word.entry_count == 7'd0)))
      else $error("empty flag disagrees with entry count");

   // failed operations return no data
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != pls_pkg::STAT_OK |-> rsp_word.read_value == '0)
      else $error("read value nonzero on failed request");

   // empty status only on an empty list
   a_empty_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == pls_pkg::STAT_EMPTY |-> rsp_word.list_empty)
      else $error("empty status with entries present");

   // one request in flight at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

endmodule

bind positional_list_store pls_checker u_pls_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the positional list store
// Runs a directed table of list operations, then random words in phases
// with different idle patterns on both channels. Each accepted request
// updates a list mirror, and it or a typed row gives the response that the
// block must return. Responses are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;

   // kind value the block decodes as a no-op
   localparam logic [2:0] KIND_UNUSED = 3'd7;
   localparam int RANDOM_PHASE_WORDS  = 120;
   localparam int BIAS_SEGMENT        = 120;
   localparam int HOLD_CYCLES         = 300;
   localparam int SETTLE_CYCLES       = 12;

   // one row of the directed table; a row can repeat with random values
   typedef struct {
      logic [2:0]       kind;
      logic [6:0]       position;
      logic [31:0]      value;
      int               reps;
      bit               typed;
      pls_pkg::rsp_type want;
   } step_row_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pls_pkg::req_type req_word  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pls_pkg::rsp_type rsp_word;

   // mirror of the list contents
   logic signed [31:0] mirror_cells [pls_pkg::CAPACITY];
   int                 mirror_len = 0;

   pls_pkg::rsp_type rsp_owed [$];
   step_row_type     plan [$];

   int  send_idle_pct  = 0;
   int  rsp_stall_pct  = 0;
   bit  long_hold      = 1'b0;
   int  words_sent     = 0;
   int  rsp_checked    = 0;
   int  full_hits      = 0;
   int  empty_hits     = 0;
   int  mismatches     = 0;

   logic [2:0]  grow_kinds   [3] = '{pls_pkg::KIND_PUSH_FRONT, pls_pkg::KIND_PUSH_BACK,
                                     pls_pkg::KIND_INSERT};
   logic [2:0]  shrink_kinds [4] = '{pls_pkg::KIND_POP_FRONT, pls_pkg::KIND_POP_BACK,
                                     pls_pkg::KIND_REMOVE, pls_pkg::KIND_READ};
   logic [31:0] extreme_values [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};

   positional_list_store u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // apply one request to the mirror and return the response it owes
   function automatic pls_pkg::rsp_type list_apply(input pls_pkg::req_type w);
      pls_pkg::rsp_type r;
      int               at;
      r = '0;
      r.status = pls_pkg::STAT_OK;
      case (w.kind) inside
         pls_pkg::KIND_PUSH_FRONT, pls_pkg::KIND_PUSH_BACK, pls_pkg::KIND_INSERT: begin
            // position check comes ahead of the full check
            if (w.kind == pls_pkg::KIND_INSERT &&
                (w.position == 0 || w.position > mirror_len + 1))
               r.status = pls_pkg::STAT_BAD;
            else if (mirror_len >= pls_pkg::CAPACITY)
               r.status = pls_pkg::STAT_FULL;
            else begin
               if (w.kind == pls_pkg::KIND_PUSH_FRONT)
                  at = 0;
               else if (w.kind == pls_pkg::KIND_PUSH_BACK)
                  at = mirror_len;
               else
                  at = int'(w.position) - 1;
               for (int i = mirror_len; i > at; i--)
                  mirror_cells[i] = mirror_cells[i-1];
               mirror_cells[at] = w.value;
               mirror_len++;
            end
         end
         pls_pkg::KIND_POP_FRONT, pls_pkg::KIND_POP_BACK,
         pls_pkg::KIND_REMOVE, pls_pkg::KIND_READ: begin
            if (mirror_len == 0)
               r.status = pls_pkg::STAT_EMPTY;
            else if ((w.kind == pls_pkg::KIND_REMOVE || w.kind == pls_pkg::KIND_READ) &&
                     (w.position == 0 || w.position > mirror_len))
               r.status = pls_pkg::STAT_BAD;
            else begin
               if (w.kind == pls_pkg::KIND_POP_FRONT)
                  at = 0;
               else if (w.kind == pls_pkg::KIND_POP_BACK)
                  at = mirror_len - 1;
               else
                  at = int'(w.position) - 1;
               if (w.kind == pls_pkg::KIND_READ)
                  r.read_value = mirror_cells[at];
               else begin
                  for (int i = at; i + 1 < mirror_len; i++)
                     mirror_cells[i] = mirror_cells[i+1];
                  mirror_len--;
               end
            end
         end
         default: ;
      endcase
      r.entry_count = 7'(mirror_len);
      r.list_empty  = (mirror_len == 0);
      return r;
   endfunction

   // random word, mostly in range; grow_pct steers toward full or empty
   function automatic pls_pkg::req_type random_word(input int grow_pct);
      pls_pkg::req_type w;
      int               top;
      if ($urandom_range(99) < 2)
         w.kind = KIND_UNUSED;
      else if ($urandom_range(99) < grow_pct)
         w.kind = grow_kinds[$urandom_range(2)];
      else
         w.kind = shrink_kinds[$urandom_range(3)];
      top = (w.kind == pls_pkg::KIND_INSERT) ? mirror_len + 1 : mirror_len;
      if (top > 0 && $urandom_range(99) < 85)
         w.position = 7'($urandom_range(top, 1));
      else
         w.position = 7'($urandom_range(127));
      if ($urandom_range(9) == 0)
         w.value = extreme_values[$urandom_range(3)];
      else
         w.value = $urandom;
      return w;
   endfunction

   task automatic add_row(input logic [2:0] kind, input logic [6:0] position,
                          input logic [31:0] value, input int reps, input bit typed,
                          input pls_pkg::rsp_type want);
      step_row_type row;
      row.kind     = kind;
      row.position = position;
      row.value    = value;
      row.reps     = reps;
      row.typed    = typed;
      row.want     = want;
      plan.insert(plan.size(), row);
   endtask

   // offer one word, wait for it to be taken, then log what it owes
   task automatic send_word(input pls_pkg::req_type w, input bit typed,
                            input pls_pkg::rsp_type want);
      pls_pkg::rsp_type owed;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      owed = list_apply(w);
      rsp_owed.insert(rsp_owed.size(), typed ? want : owed);
      words_sent++;
   endtask

   task automatic report_diff(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
   endtask

   // response side: random stall, or one long hold on request
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // compare each accepted response with the oldest owed one
   always @(posedge clock) begin : rsp_check
      pls_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_owed.size() == 0) begin
            $display("%0t: response with none owed, expected nothing, actual %p",
                     $time, rsp_word);
            mismatches++;
         end else begin
            want = rsp_owed[0];
            rsp_owed.delete(0);
            rsp_checked++;
            if (want.status == pls_pkg::STAT_FULL)
               full_hits++;
            if (want.status == pls_pkg::STAT_EMPTY)
               empty_hits++;
            if (rsp_word.read_value !== want.read_value)
               report_diff("read_value", want.read_value, rsp_word.read_value);
            if (rsp_word.status !== want.status)
               report_diff("status", 32'(want.status), 32'(rsp_word.status));
            if (rsp_word.entry_count !== want.entry_count)
               report_diff("entry_count", 32'(want.entry_count), 32'(rsp_word.entry_count));
            if (rsp_word.list_empty !== want.list_empty)
               report_diff("list_empty", 32'(want.list_empty), 32'(rsp_word.list_empty));
         end
      end
   end

   initial begin : run_limit
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : stimulus
      pls_pkg::req_type w;
      pls_pkg::rsp_type on_empty;
      pls_pkg::rsp_type none;
      none     = '0;
      on_empty = pls_pkg::rsp_type'{32'sd0, pls_pkg::STAT_EMPTY, 7'd0, 1'b1};

      // directed table: empty list, bad positions, extremes, full list, drain
      add_row(pls_pkg::KIND_POP_FRONT,  7'd1,   32'h0,          1, 1'b1, on_empty);
      add_row(pls_pkg::KIND_POP_BACK,   7'd1,   32'h0,          1, 1'b1, on_empty);
      add_row(pls_pkg::KIND_REMOVE,     7'd1,   32'h0,          1, 1'b1, on_empty);
      add_row(pls_pkg::KIND_READ,       7'd1,   32'h0,          1, 1'b1, on_empty);
      add_row(pls_pkg::KIND_INSERT,     7'd0,   32'h5,          1, 1'b1,
              pls_pkg::rsp_type'{32'sd0, pls_pkg::STAT_BAD, 7'd0, 1'b1});
      add_row(pls_pkg::KIND_INSERT,     7'd2,   32'h5,          1, 1'b1,
              pls_pkg::rsp_type'{32'sd0, pls_pkg::STAT_BAD, 7'd0, 1'b1});
      add_row(KIND_UNUSED,              7'd127, 32'hFFFF_FFFF,  1, 1'b1,
              pls_pkg::rsp_type'{32'sd0, pls_pkg::STAT_OK, 7'd0, 1'b1});
      add_row(pls_pkg::KIND_PUSH_FRONT, 7'd0,   32'h7FFF_FFFF,  1, 1'b0, none);
      add_row(pls_pkg::KIND_PUSH_BACK,  7'd0,   32'h8000_0000,  1, 1'b0, none);
      add_row(pls_pkg::KIND_INSERT,     7'd2,   32'hFFFF_FFFF,  1, 1'b0, none);
      add_row(pls_pkg::KIND_INSERT,     7'd4,   32'h0,          1, 1'b0, none);
      add_row(pls_pkg::KIND_READ,       7'd1,   32'h0,          1, 1'b0, none);
      add_row(pls_pkg::KIND_READ,       7'd4,   32'h0,          1, 1'b0, none);
      add_row(pls_pkg::KIND_READ,       7'd0,   32'h0,          1, 1'b1,
              pls_pkg::rsp_type'{32'sd0, pls_pkg::STAT_BAD, 7'd4, 1'b0});
      add_row(pls_pkg::KIND_READ,       7'd5,   32'h0,          1, 1'b1,
              pls_pkg::rsp_type'{32'sd0, pls_pkg::STAT_BAD, 7'd4, 1'b0});
      add_row(pls_pkg::KIND_REMOVE,     7'd127, 32'h0,          1, 1'b1,
              pls_pkg::rsp_type'{32'sd0, pls_pkg::STAT_BAD, 7'd4, 1'b0});
      add_row(pls_pkg::KIND_REMOVE,     7'd2,   32'h0,          1, 1'b0, none);
      // fill to capacity; the last push finds the list full
      add_row(pls_pkg::KIND_PUSH_BACK,  7'd0,   32'h0,         62, 1'b0, none);
      add_row(pls_pkg::KIND_PUSH_FRONT, 7'd0,   32'h1234_5678,  1, 1'b1,
              pls_pkg::rsp_type'{32'sd0, pls_pkg::STAT_FULL, 7'd64, 1'b0});
      add_row(pls_pkg::KIND_INSERT,     7'd66,  32'h1,          1, 1'b1,
              pls_pkg::rsp_type'{32'sd0, pls_pkg::STAT_BAD, 7'd64, 1'b0});
      add_row(pls_pkg::KIND_INSERT,     7'd65,  32'h1,          1, 1'b1,
              pls_pkg::rsp_type'{32'sd0, pls_pkg::STAT_FULL, 7'd64, 1'b0});
      add_row(pls_pkg::KIND_READ,       7'd64,  32'h0,          1, 1'b0, none);
      add_row(pls_pkg::KIND_REMOVE,     7'd64,  32'h0,          1, 1'b0, none);
      add_row(pls_pkg::KIND_INSERT,     7'd64,  32'hA5A5_5A5A,  1, 1'b0, none);
      // drain past empty
      add_row(pls_pkg::KIND_POP_FRONT,  7'd0,   32'h0,         66, 1'b0, none);
      add_row(pls_pkg::KIND_POP_BACK,   7'd0,   32'h0,          1, 1'b1, on_empty);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         for (int n = 0; n < plan[i].reps; n++) begin
            w.kind     = plan[i].kind;
            w.position = plan[i].position;
            w.value    = (plan[i].reps > 1) ? $urandom : plan[i].value;
            send_word(w, plan[i].typed, plan[i].want);
         end
      end

      // random phases: none, sender idle, receiver stall, both, long hold
      for (int p = 0; p < 5; p++) begin
         case (p)
            1:       begin send_idle_pct = 67; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 67; end
            3:       begin send_idle_pct = 17; rsp_stall_pct = 17; end
            default: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         endcase
         if (p == 4)
            long_hold = 1'b1;
         for (int k = 0; k < RANDOM_PHASE_WORDS; k++) begin
            // alternate long growing and shrinking stretches
            w = random_word(((words_sent / BIAS_SEGMENT) % 2 == 0) ? 75 : 25);
            send_word(w, 1'b0, none);
         end
      end
      req_valid <= 1'b0;

      while (rsp_owed.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run: %0d request words under five idle patterns, one long response hold.",
               words_sent);
      $display("Checked %0d responses: %0d on a full list, %0d on an empty one, %0d mismatches.",
               rsp_checked, full_hits, empty_hits, mismatches);
      if (mismatches == 0 && rsp_owed.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/pls_pkg.sv
hdl/pls_cell.sv
hdl/positional_list_store.sv
hdl/pls_checker.sv
tb/tb.sv
